// File: rtl/stp_pwm_pkg.sv
// shared types, constants and speed table for the stepper speed to step pwm block
package stp_pwm_pkg;

  localparam int ROM_ROWS    = 26;
  localparam int TABLE_ROWS  = 26;
  localparam int SEARCH_ROWS = (TABLE_ROWS < ROM_ROWS) ? TABLE_ROWS : ROM_ROWS;

  localparam int NUM_W   = 22;
  localparam int DEN_W   = 8;
  localparam int QUO_W   = 16;
  localparam int SPAN_W  = 7;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [9:0]  SPEED_MAX    = 10'd1000;
  localparam logic [8:0]  STOP_DIVIDER = 9'd256;
  localparam logic [15:0] STOP_PERIOD  = 16'hFFFF;

  typedef struct packed {
    logic [9:0]  lo;
    logic [9:0]  hi;
    logic [8:0]  divider;
    logic [15:0] p_lo;
    logic [15:0] p_hi;
  } rom_row_t;

  localparam rom_row_t ROM_TABLE [0:ROM_ROWS-1] = '{
    '{10'd1,   10'd1,    9'd224, 16'd28912, 16'd28912},
    '{10'd2,   10'd2,    9'd112, 16'd28912, 16'd28912},
    '{10'd3,   10'd3,    9'd80,  16'd26984, 16'd26984},
    '{10'd4,   10'd4,    9'd56,  16'd28912, 16'd28912},
    '{10'd5,   10'd6,    9'd40,  16'd32381, 16'd26984},
    '{10'd7,   10'd7,    9'd32,  16'd28912, 16'd28912},
    '{10'd8,   10'd8,    9'd28,  16'd28912, 16'd28912},
    '{10'd9,   10'd9,    9'd24,  16'd29983, 16'd29983},
    '{10'd10,  10'd12,   9'd20,  16'd32381, 16'd26984},
    '{10'd13,  10'd14,   9'd16,  16'd31136, 16'd28912},
    '{10'd15,  10'd16,   9'd14,  16'd30839, 16'd28912},
    '{10'd17,  10'd19,   9'd12,  16'd31746, 16'd28405},
    '{10'd20,  10'd24,   9'd10,  16'd32381, 16'd26984},
    '{10'd25,  10'd32,   9'd8,   16'd32381, 16'd25298},
    '{10'd33,  10'd49,   9'd6,   16'd32708, 16'd22028},
    '{10'd50,  10'd98,   9'd4,   16'd32381, 16'd16521},
    '{10'd99,  10'd197,  9'd2,   16'd32708, 16'd16437},
    '{10'd198, 10'd297,  9'd1,   16'd32708, 16'd21806},
    '{10'd298, 10'd397,  9'd1,   16'd21732, 16'd16313},
    '{10'd398, 10'd497,  9'd1,   16'd16272, 16'd13031},
    '{10'd498, 10'd597,  9'd1,   16'd13005, 16'd10848},
    '{10'd598, 10'd697,  9'd1,   16'd10830, 16'd9292},
    '{10'd698, 10'd797,  9'd1,   16'd9278,  16'd8126},
    '{10'd798, 10'd897,  9'd1,   16'd8116,  16'd7220},
    '{10'd898, 10'd997,  9'd1,   16'd7212,  16'd6496},
    '{10'd998, 10'd1000, 9'd1,   16'd6489,  16'd6476}
  };

  typedef struct packed {
    logic [8:0]        divider;
    logic [15:0]       p_lo;
    logic [15:0]       d;
    logic [SPAN_W-1:0] x;
    logic [SPAN_W-1:0] h;
    logic              direction;
    logic              enable;
  } cmd_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic [8:0]       divider;
    logic [15:0]      p_lo;
    logic             direction;
    logic             enable;
  } div_t;

endpackage

// File: rtl/stp_pwm_front.sv
// front end: magnitude, clamp and speed table row search
module stp_pwm_front (
  input  logic signed [15:0]  in_speed_command,
  output stp_pwm_pkg::cmd_t   cmd
);

  logic                neg;
  logic [16:0]         mag;
  logic [9:0]          m;
  logic                found;
  stp_pwm_pkg::rom_row_t sel;
  logic [9:0]          x_full;
  logic [9:0]          h_full;

  always_comb begin
    neg   = in_speed_command[15];
    mag   = neg ? (17'h10000 - {1'b0, in_speed_command}) : {1'b0, in_speed_command};
    m     = (mag > {7'd0, stp_pwm_pkg::SPEED_MAX}) ? stp_pwm_pkg::SPEED_MAX : mag[9:0];
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < stp_pwm_pkg::SEARCH_ROWS; i++) begin
      if (!found && (m != 10'd0) && (stp_pwm_pkg::ROM_TABLE[i].lo <= m) &&
          (m <= stp_pwm_pkg::ROM_TABLE[i].hi)) begin
        found = 1'b1;
        sel   = stp_pwm_pkg::ROM_TABLE[i];
      end
    end
    x_full        = m - sel.lo;
    h_full        = sel.hi - sel.lo;
    cmd.direction = !neg;
    cmd.enable    = found;
    if (found) begin
      cmd.divider = sel.divider;
      cmd.p_lo    = sel.p_lo;
      cmd.d       = sel.p_lo - sel.p_hi;
      cmd.x       = x_full[stp_pwm_pkg::SPAN_W-1:0];
      cmd.h       = h_full[stp_pwm_pkg::SPAN_W-1:0];
    end else begin
      cmd.divider = stp_pwm_pkg::STOP_DIVIDER;
      cmd.p_lo    = stp_pwm_pkg::STOP_PERIOD;
      cmd.d       = '0;
      cmd.x       = '0;
      cmd.h       = '0;
    end
  end

endmodule

// File: rtl/stp_pwm_queue.sv
// small fifo between front end and divider pipeline
module stp_pwm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  stp_pwm_pkg::cmd_t  push_data,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output stp_pwm_pkg::cmd_t  pop_data
);

  stp_pwm_pkg::cmd_t                  mem_r [0:stp_pwm_pkg::Q_DEPTH-1];
  logic [stp_pwm_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [stp_pwm_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [stp_pwm_pkg::Q_PTR_W:0]      count_r, count_nxt;
  logic                               do_push;
  logic                               do_pop;

  always_comb begin
    full       = (count_r == (stp_pwm_pkg::Q_PTR_W + 1)'(stp_pwm_pkg::Q_DEPTH));
    pop_valid  = (count_r != '0);
    pop_data   = mem_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && pop_valid;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{stp_pwm_pkg::Q_PTR_W{1'b0}}, do_push}
                         - {{stp_pwm_pkg::Q_PTR_W{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/stp_pwm_back.sv
// back end: interpolation multiply, pipelined rounding divider, output register
module stp_pwm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  stp_pwm_pkg::cmd_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         out_clock_divider,
  output logic [15:0]        out_period_ticks,
  output logic [14:0]        out_high_ticks,
  output logic               out_direction,
  output logic               out_drive_enable
);

  localparam int NSTG = stp_pwm_pkg::QUO_W;

  stp_pwm_pkg::div_t stg_r   [0:NSTG];
  stp_pwm_pkg::div_t stg0_nxt;
  stp_pwm_pkg::div_t stg_nxt [1:NSTG];
  logic [NSTG:0]     vld_r;
  logic              adv;
  logic [22:0]       prod;
  logic [23:0]       num_full;
  logic [15:0]       period_nxt;
  logic              out_valid_r;
  logic [8:0]        divider_r;
  logic [15:0]       period_r;
  logic [14:0]       high_r;
  logic              direction_r;
  logic              enable_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv;

  // stage 0: numerator 2*d*x + h and denominator 2*h, or numerator 0 over denominator 1 when h is zero
  always_comb begin
    prod     = q_data.d * q_data.x;
    num_full = {prod, 1'b0} + 24'(q_data.h);
    stg0_nxt.quo       = '0;
    stg0_nxt.divider   = q_data.divider;
    stg0_nxt.p_lo      = q_data.p_lo;
    stg0_nxt.direction = q_data.direction;
    stg0_nxt.enable    = q_data.enable;
    if (q_data.h == '0) begin
      stg0_nxt.rem = '0;
      stg0_nxt.den = stp_pwm_pkg::DEN_W'(1);
    end else begin
      stg0_nxt.rem = num_full[stp_pwm_pkg::NUM_W-1:0];
      stg0_nxt.den = {q_data.h, 1'b0};
    end
  end

  // one quotient bit per stage, msb first
  always_comb begin
    for (int k = 1; k <= NSTG; k++) begin
      logic [NSTG+stp_pwm_pkg::NUM_W-1:0] trial;
      trial      = ({{(NSTG+stp_pwm_pkg::NUM_W-stp_pwm_pkg::DEN_W){1'b0}}, stg_r[k-1].den})
                   << (NSTG - k);
      stg_nxt[k] = stg_r[k-1];
      if ({{NSTG{1'b0}}, stg_r[k-1].rem} >= trial) begin
        stg_nxt[k].rem           = stg_r[k-1].rem - trial[stp_pwm_pkg::NUM_W-1:0];
        stg_nxt[k].quo[NSTG - k] = 1'b1;
      end
    end
  end

  assign period_nxt = stg_r[NSTG].p_lo - stg_r[NSTG].quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-1:0], q_valid};
      out_valid_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= stg0_nxt;
      for (int k = 1; k <= NSTG; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
      divider_r   <= stg_r[NSTG].divider;
      period_r    <= period_nxt;
      high_r      <= stg_r[NSTG].enable ? period_nxt[15:1] : 15'd0;
      direction_r <= stg_r[NSTG].direction;
      enable_r    <= stg_r[NSTG].enable;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_clock_divider = divider_r;
  assign out_period_ticks  = period_r;
  assign out_high_ticks    = high_r;
  assign out_direction     = direction_r;
  assign out_drive_enable  = enable_r;

endmodule

// File: rtl/stepper_speed_to_step_pwm.sv
// top level: speed command to step pulse generator settings
// an accepted beat passes the queue, stage 0, 16 divider stages and the output register
// throughput: one beat per cycle when not stalled; the divider takes one quotient bit per stage
// a 4-entry queue separates the table lookup from the divider pipeline
// reset (synchronous, rst_n low) clears the queue pointers and count and the pipeline valid bits
// no clearing pass: input is accepted on the first cycle after reset
module stepper_speed_to_step_pwm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_speed_command,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         out_clock_divider,
  output logic [15:0]        out_period_ticks,
  output logic [14:0]        out_high_ticks,
  output logic               out_direction,
  output logic               out_drive_enable
);

  stp_pwm_pkg::cmd_t front_cmd;
  stp_pwm_pkg::cmd_t q_data;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  stp_pwm_front u_front (
    .in_speed_command (in_speed_command),
    .cmd              (front_cmd)
  );

  stp_pwm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  stp_pwm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_clock_divider (out_clock_divider),
    .out_period_ticks  (out_period_ticks),
    .out_high_ticks    (out_high_ticks),
    .out_direction     (out_direction),
    .out_drive_enable  (out_drive_enable)
  );

  assign in_stall = q_full;

endmodule

// File: rtl/stp_pwm_checker.sv
// port-level checker for the stepper speed to step pwm block, with bind
module stp_pwm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [8:0]  out_clock_divider,
  input logic [15:0] out_period_ticks,
  input logic [14:0] out_high_ticks,
  input logic        out_direction,
  input logic        out_drive_enable
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_period_ticks) &&
    $stable(out_clock_divider) && $stable(out_high_ticks) &&
    $stable(out_direction) && $stable(out_drive_enable))
    else $error("stalled output beat changed");

  // stopped beat carries the stop settings
  a_stop_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive_enable |-> out_high_ticks == 15'd0 &&
    out_period_ticks == 16'hFFFF && out_clock_divider == 9'd256)
    else $error("stopped beat has wrong settings");

  // high time is half the period when driving
  a_half_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_enable |-> out_high_ticks == out_period_ticks[15:1])
    else $error("high time is not half the period");

  // driving divider comes from the table
  a_divider_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_enable |-> out_clock_divider != 9'd0 &&
    out_clock_divider <= 9'd224 && out_period_ticks != 16'hFFFF)
    else $error("driving beat has divider or period outside the table");

endmodule

bind stepper_speed_to_step_pwm stp_pwm_checker u_stp_pwm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_clock_divider (out_clock_divider),
  .out_period_ticks  (out_period_ticks),
  .out_high_ticks    (out_high_ticks),
  .out_direction     (out_direction),
  .out_drive_enable  (out_drive_enable)
);

// File: tb/tb_stepper_speed_to_step_pwm.sv
// self-checking testbench for the stepper speed to step pwm block, with its own step settings predictor
module tb_stepper_speed_to_step_pwm;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ROWS      = 26;
  localparam int RANDOM_BEATS  = 375;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {
    BURST_FULL,
    SRC_GAPS,
    SINK_STALLS,
    BOTH_GAPS
  } traffic_mode_t;

  typedef struct packed {
    logic [8:0]  clock_divider;
    logic [15:0] period_ticks;
    logic [14:0] high_ticks;
    logic        direction;
    logic        drive_enable;
  } step_settings_t;

  typedef struct {
    logic signed [15:0] speed;
    step_settings_t     settings;
  } pending_settings_t;

  // lo, hi, divider, period at lo, period at hi
  localparam int unsigned STEP_RANGES [0:NUM_ROWS-1][0:4] = '{
    '{  1,    1, 224, 28912, 28912},
    '{  2,    2, 112, 28912, 28912},
    '{  3,    3,  80, 26984, 26984},
    '{  4,    4,  56, 28912, 28912},
    '{  5,    6,  40, 32381, 26984},
    '{  7,    7,  32, 28912, 28912},
    '{  8,    8,  28, 28912, 28912},
    '{  9,    9,  24, 29983, 29983},
    '{ 10,   12,  20, 32381, 26984},
    '{ 13,   14,  16, 31136, 28912},
    '{ 15,   16,  14, 30839, 28912},
    '{ 17,   19,  12, 31746, 28405},
    '{ 20,   24,  10, 32381, 26984},
    '{ 25,   32,   8, 32381, 25298},
    '{ 33,   49,   6, 32708, 22028},
    '{ 50,   98,   4, 32381, 16521},
    '{ 99,  197,   2, 32708, 16437},
    '{198,  297,   1, 32708, 21806},
    '{298,  397,   1, 21732, 16313},
    '{398,  497,   1, 16272, 13031},
    '{498,  597,   1, 13005, 10848},
    '{598,  697,   1, 10830,  9292},
    '{698,  797,   1,  9278,  8126},
    '{798,  897,   1,  8116,  7220},
    '{898,  997,   1,  7212,  6496},
    '{998, 1000,   1,  6489,  6476}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_speed_command;
  logic               out_valid;
  logic               out_stall;
  logic [8:0]         out_clock_divider;
  logic [15:0]        out_period_ticks;
  logic [14:0]        out_high_ticks;
  logic               out_direction;
  logic               out_drive_enable;

  logic signed [15:0] speed_queue [$];
  pending_settings_t  settings_due [$];
  traffic_mode_t      traffic_mode;
  int                 mismatch_count;
  int                 idle_cycles;

  stepper_speed_to_step_pwm dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_speed_command (in_speed_command),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_clock_divider(out_clock_divider),
    .out_period_ticks (out_period_ticks),
    .out_high_ticks   (out_high_ticks),
    .out_direction    (out_direction),
    .out_drive_enable (out_drive_enable)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic step_settings_t predict_step_settings(logic signed [15:0] speed);
    step_settings_t s;
    int unsigned    mag;
    int unsigned    span;
    int unsigned    offset;
    int unsigned    drop;
    int unsigned    correction;
    int unsigned    period;
    int             rows;
    bit             found;
    s.clock_divider = stp_pwm_pkg::STOP_DIVIDER;
    s.period_ticks  = stp_pwm_pkg::STOP_PERIOD;
    s.high_ticks    = '0;
    s.direction     = ~speed[15];
    s.drive_enable  = 1'b0;
    mag = speed[15] ? (32'h10000 - {16'd0, speed}) : {16'd0, speed};
    if (mag > 1000) mag = 1000;
    rows = (stp_pwm_pkg::TABLE_ROWS < NUM_ROWS) ? stp_pwm_pkg::TABLE_ROWS : NUM_ROWS;
    found = 1'b0;
    if (mag != 0) begin
      for (int i = 0; i < rows; i++) begin
        if (!found && STEP_RANGES[i][0] <= mag && mag <= STEP_RANGES[i][1]) begin
          found = 1'b1;
          span   = STEP_RANGES[i][1] - STEP_RANGES[i][0];
          offset = mag - STEP_RANGES[i][0];
          drop   = STEP_RANGES[i][3] - STEP_RANGES[i][4];
          if (span == 0 || drop == 0) begin
            period = STEP_RANGES[i][3];
          end else begin
            correction = (2 * drop * offset + span) / (2 * span);
            period = STEP_RANGES[i][3] - correction;
          end
          s.clock_divider = 9'(STEP_RANGES[i][2]);
          s.period_ticks  = 16'(period);
          s.high_ticks    = 15'(period / 2);
          s.drive_enable  = 1'b1;
        end
      end
    end
    return s;
  endfunction

  function automatic logic signed [15:0] random_speed();
    int unsigned roll;
    int unsigned mag;
    int          row;
    roll = $urandom_range(99);
    if (roll < 30) begin
      return 16'($urandom_range(16'hFFFF, 0));
    end else if (roll < 75) begin
      mag = $urandom_range(1000);
    end else begin
      row = $urandom_range(NUM_ROWS - 1);
      mag = STEP_RANGES[row][$urandom_range(1)] + $urandom_range(2) - 1;
    end
    return $urandom_range(1) ? -$signed(mag[15:0]) : $signed(mag[15:0]);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_speed_command <= '0;
    end else if (!in_valid || !in_stall) begin
      if (speed_queue.size() > 0 &&
          !((traffic_mode == SRC_GAPS && $urandom_range(99) < 58) ||
            (traffic_mode == BOTH_GAPS && $urandom_range(99) < 21))) begin
        in_valid         <= 1'b1;
        in_speed_command <= speed_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin : result_check
    pending_settings_t expd;
    step_settings_t    got;
    if (!rst_n) begin
      out_stall   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expd.speed    = in_speed_command;
        expd.settings = predict_step_settings(in_speed_command);
        settings_due.push_back(expd);
      end
      if (out_valid && !out_stall) begin
        got = '{out_clock_divider, out_period_ticks, out_high_ticks,
                out_direction, out_drive_enable};
        if (settings_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected beat: div %0d per %0d high %0d dir %0b en %0b",
                     got.clock_divider, got.period_ticks, got.high_ticks,
                     got.direction, got.drive_enable);
        end else begin
          expd = settings_due.pop_front();
          if (got.clock_divider !== expd.settings.clock_divider ||
              got.period_ticks !== expd.settings.period_ticks ||
              got.high_ticks !== expd.settings.high_ticks ||
              got.direction !== expd.settings.direction ||
              got.drive_enable !== expd.settings.drive_enable) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display({"mismatch speed %0d: exp div %0d per %0d high %0d dir %0b en %0b",
                        " got div %0d per %0d high %0d dir %0b en %0b"},
                       expd.speed, expd.settings.clock_divider,
                       expd.settings.period_ticks, expd.settings.high_ticks,
                       expd.settings.direction, expd.settings.drive_enable,
                       got.clock_divider, got.period_ticks, got.high_ticks,
                       got.direction, got.drive_enable);
          end
        end
      end
      out_stall <= (traffic_mode == SINK_STALLS && $urandom_range(99) < 58) ||
                   (traffic_mode == BOTH_GAPS && $urandom_range(99) < 21);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_speed_command = '0;
    out_stall        = 1'b0;
    traffic_mode     = BURST_FULL;
    mismatch_count   = 0;
    idle_cycles      = 0;
    // zero, saturation, sign extremes and range edges
    speed_queue = '{16'sd0, 16'sd1, -16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6,
                    16'sd12, 16'sd50, 16'sd98, 16'sd99, 16'sd197, 16'sd198,
                    -16'sd500, 16'sd997, 16'sd998, 16'sd999, 16'sd1000, 16'sd1001,
                    -16'sd1000, -16'sd1001, 16'sd32767, -16'sd32768, -16'sd32767};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int m = 0; m < 4; m++) begin
      traffic_mode = traffic_mode_t'(m);
      for (int i = 0; i < RANDOM_BEATS; i++)
        speed_queue.push_back(random_speed());
      while (speed_queue.size() > 0) @(posedge clk);
    end
    while (in_valid || settings_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && settings_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: stepper_speed_to_step_pwm.f
rtl/stp_pwm_pkg.sv
rtl/stp_pwm_front.sv
rtl/stp_pwm_queue.sv
rtl/stp_pwm_back.sv
rtl/stepper_speed_to_step_pwm.sv
rtl/stp_pwm_checker.sv
tb/tb_stepper_speed_to_step_pwm.sv
